>>> design/lpd_pkg.sv
`timescale 1ns / 1ps

// Shared types and constants of the length prefix deframer.
package lpd_pkg;

	// Header storage and its index widths.
	localparam int MaxHeaderBytes = 8;
	localparam int HdrIdxW = $clog2(MaxHeaderBytes);
	localparam int HdrCntW = $clog2(MaxHeaderBytes + 1);

	// Command queue between the front and the back.
	localparam int QueueDepth = 8;
	localparam int QPtrW = $clog2(QueueDepth);
	localparam int QCntW = $clog2(QueueDepth + 1);

	// Fixed field widths.
	localparam int ByteW = 8;
	localparam int LenW = 32;
	localparam int HlenW = 4;
	localparam int ErrW = 2;
	localparam int AddrW = 4;
	localparam int RegIdxW = 2;

	// Error codes carried on error_code.
	localparam logic [ErrW-1:0] ERR_NONE = 2'd0;
	localparam logic [ErrW-1:0] ERR_SHORT = 2'd1;
	localparam logic [ErrW-1:0] ERR_LONG = 2'd2;

	// Register indexes (word address bits of paddr).
	localparam logic [RegIdxW-1:0] REG_TEXT_MODE = 2'd0;
	localparam logic [RegIdxW-1:0] REG_HEADER_LEN = 2'd1;
	localparam logic [RegIdxW-1:0] REG_MAX_LEN = 2'd2;

	// Kind of a queued command.
	typedef enum logic [1:0] {
		KIND_HDR = 2'd0,
		KIND_BODY = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	// Configuration as seen by the front.
	typedef struct packed {
		logic text_mode;
		logic [HlenW-1:0] header_len;
		logic [LenW-1:0] max_len;
	} cfg_t;

	// One queued command: a header burst, a body byte or an error.
	typedef struct packed {
		kind_t kind;
		logic [MaxHeaderBytes-1:0][ByteW-1:0] bytes;
		logic [HlenW-1:0] hlen;
		logic [LenW-1:0] len;
		logic last;
		logic [ErrW-1:0] err;
	} entry_t;

endpackage

>>> design/length_prefix_deframer.sv
`timescale 1ns / 1ps

// Length prefix deframer: cuts a byte stream into packets whose header gives
// the total length, header included, as a 2- or 4-byte big-endian number or
// as header_len ASCII hex characters. It takes one byte per cycle. Header
// bytes are held and, on the header's last byte, leave as a burst of one
// result per header byte, one per cycle while the output does not stall,
// from an eight-entry command queue; body bytes follow one result each. A
// result passes through the queue and then the output register. The input
// stalls only when the command queue is full and no command retires in that
// cycle, which happens while the output side stalls or while a header burst
// is still going out. A bad length gives one error result and the block then
// ignores all input until reset. Registers: text_mode at 0x0, header_len at
// 0x4, max_packet_len at 0x8; write them only while the block is idle.
module length_prefix_deframer (
	input logic clk,
	input logic arst_n,
	// Configuration port.
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [lpd_pkg::AddrW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// Byte input.
	input logic in_valid,
	output logic in_stall,
	input logic [lpd_pkg::ByteW-1:0] data_byte,
	// Result output.
	output logic out_valid,
	input logic out_stall,
	output logic [lpd_pkg::ByteW-1:0] out_byte,
	output logic first_of_packet,
	output logic last_of_packet,
	output logic [lpd_pkg::LenW-1:0] packet_length,
	output logic [lpd_pkg::ErrW-1:0] error_code,
	output logic end_of_burst
);

	logic text_mode_q;
	logic [lpd_pkg::HlenW-1:0] header_len_q;
	logic [lpd_pkg::LenW-1:0] max_len_q;
	logic wr_en;
	logic [lpd_pkg::RegIdxW-1:0] reg_idx;
	lpd_pkg::cfg_t cfg;

	logic q_full;
	logic q_block;
	logic q_empty;
	logic push;
	logic pop;
	lpd_pkg::entry_t push_entry;
	lpd_pkg::entry_t head;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[lpd_pkg::AddrW-1:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_mode_q <= 1'b0;
			header_len_q <= 4'd2;
			max_len_q <= 32'd65536;
		end else if (wr_en) begin
			case (reg_idx)
				lpd_pkg::REG_TEXT_MODE: text_mode_q <= pwdata[0];
				lpd_pkg::REG_HEADER_LEN: header_len_q <= pwdata[lpd_pkg::HlenW-1:0];
				lpd_pkg::REG_MAX_LEN: max_len_q <= pwdata;
				default: begin
					max_len_q <= max_len_q;
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (reg_idx)
			lpd_pkg::REG_TEXT_MODE: prdata = {31'd0, text_mode_q};
			lpd_pkg::REG_HEADER_LEN: prdata = {28'd0, header_len_q};
			lpd_pkg::REG_MAX_LEN: prdata = max_len_q;
			default: prdata = '0;
		endcase
	end

	assign cfg.text_mode = text_mode_q;
	assign cfg.header_len = header_len_q;
	assign cfg.max_len = max_len_q;

	// A full queue still takes a command in a cycle in which the back retires one.
	assign q_block = q_full && !pop;

	lpd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.data_byte(data_byte),
		.q_full(q_block),
		.in_stall(in_stall),
		.push(push),
		.push_entry(push_entry)
	);

	lpd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.full(q_full),
		.empty(q_empty),
		.head(head)
	);

	lpd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(q_empty),
		.pop(pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.first_of_packet(first_of_packet),
		.last_of_packet(last_of_packet),
		.packet_length(packet_length),
		.error_code(error_code),
		.end_of_burst(end_of_burst)
	);

endmodule

>>> design/lpd_front.sv
`timescale 1ns / 1ps

// Front part: takes stream bytes, gathers the header, decodes and checks the
// length, and pushes one command per completed header or body byte.
module lpd_front (
	input logic clk,
	input logic arst_n,
	input lpd_pkg::cfg_t cfg,
	input logic in_valid,
	input logic [lpd_pkg::ByteW-1:0] data_byte,
	input logic q_full,
	output logic in_stall,
	output logic push,
	output lpd_pkg::entry_t push_entry
);

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_BODY = 3'b010,
		PH_CLOSED = 3'b100
	} phase_t;

	phase_t phase_q;
	logic [lpd_pkg::HdrCntW-1:0] cnt_q;
	logic [lpd_pkg::LenW-1:0] bytes_left_q;
	logic [lpd_pkg::LenW-1:0] len_q;
	logic [lpd_pkg::MaxHeaderBytes-1:0][lpd_pkg::ByteW-1:0] store_q;

	logic acc;
	logic [lpd_pkg::HlenW-1:0] hl_eff;
	logic [lpd_pkg::HdrCntW-1:0] cnt_inc;
	logic hdr_done;
	logic [lpd_pkg::MaxHeaderBytes-1:0][lpd_pkg::ByteW-1:0] hdr_vec;
	logic [lpd_pkg::LenW-1:0] dec_len;
	logic is_short;
	logic is_long;

	// Returns {valid, value} of one ASCII hex character.
	function automatic logic [4:0] hex_digit(input logic [lpd_pkg::ByteW-1:0] c);
		logic [lpd_pkg::ByteW-1:0] t;
		t = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			return {1'b1, t[3:0]};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			return {1'b1, t[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			return {1'b1, t[3:0]};
		end
		return 5'd0;
	endfunction

	// Hex digits up to the first non-digit, within the first hl characters.
	function automatic logic [lpd_pkg::LenW-1:0] hex_decode(
		input logic [lpd_pkg::MaxHeaderBytes-1:0][lpd_pkg::ByteW-1:0] h,
		input logic [lpd_pkg::HlenW-1:0] hl
	);
		logic [lpd_pkg::LenW-1:0] a;
		logic stop;
		logic [4:0] d;
		a = '0;
		stop = 1'b0;
		for (int i = 0; i < lpd_pkg::MaxHeaderBytes; i++) begin
			d = hex_digit(h[i]);
			if (lpd_pkg::HlenW'(i) < hl) begin
				if (stop || !d[4]) begin
					stop = 1'b1;
				end else begin
					a = {a[lpd_pkg::LenW-5:0], d[3:0]};
				end
			end
		end
		return a;
	endfunction

	assign acc = in_valid && !in_stall;
	assign in_stall = q_full;

	// Header size in force: zero acts as one, oversize is clipped.
	always_comb begin
		if (cfg.header_len == '0) begin
			hl_eff = lpd_pkg::HlenW'(1);
		end else if (cfg.header_len > lpd_pkg::HlenW'(lpd_pkg::MaxHeaderBytes)) begin
			hl_eff = lpd_pkg::HlenW'(lpd_pkg::MaxHeaderBytes);
		end else begin
			hl_eff = cfg.header_len;
		end
	end

	assign cnt_inc = cnt_q + 1'b1;
	assign hdr_done = lpd_pkg::HlenW'(cnt_inc) >= hl_eff;

	// Stored header with the incoming byte placed at its slot.
	always_comb begin
		for (int i = 0; i < lpd_pkg::MaxHeaderBytes; i++) begin
			hdr_vec[i] = (cnt_q[lpd_pkg::HdrIdxW-1:0] == lpd_pkg::HdrIdxW'(i)) ?
				data_byte : store_q[i];
		end
	end

	// Length decode in either header format.
	always_comb begin
		if (cfg.text_mode) begin
			dec_len = hex_decode(hdr_vec, hl_eff);
		end else if (hl_eff == 4'd2) begin
			dec_len = {16'd0, hdr_vec[0], hdr_vec[1]};
		end else if (hl_eff == 4'd4) begin
			dec_len = {hdr_vec[0], hdr_vec[1], hdr_vec[2], hdr_vec[3]};
		end else begin
			dec_len = '0;
		end
	end

	assign is_short = (dec_len == '0) ||
		(dec_len < {{(lpd_pkg::LenW - lpd_pkg::HlenW){1'b0}}, hl_eff});
	assign is_long = dec_len > cfg.max_len;

	// Command built for the queue.
	always_comb begin
		push = 1'b0;
		push_entry = '0;
		push_entry.kind = lpd_pkg::KIND_BODY;
		push_entry.bytes = hdr_vec;
		push_entry.hlen = hl_eff;
		push_entry.len = len_q;
		push_entry.err = lpd_pkg::ERR_NONE;
		if (acc) begin
			case (phase_q)
				PH_HEADER: begin
					if (hdr_done) begin
						push = 1'b1;
						push_entry.len = dec_len;
						if (is_short) begin
							push_entry.kind = lpd_pkg::KIND_ERR;
							push_entry.err = lpd_pkg::ERR_SHORT;
						end else if (is_long) begin
							push_entry.kind = lpd_pkg::KIND_ERR;
							push_entry.err = lpd_pkg::ERR_LONG;
						end else begin
							push_entry.kind = lpd_pkg::KIND_HDR;
							push_entry.last = dec_len ==
								{{(lpd_pkg::LenW - lpd_pkg::HlenW){1'b0}}, hl_eff};
						end
					end
				end
				PH_BODY: begin
					push = 1'b1;
					push_entry.bytes[0] = data_byte;
					push_entry.last = bytes_left_q <= 1;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// Phase, header count and body countdown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q <= '0;
			bytes_left_q <= '0;
			len_q <= '0;
		end else if (acc) begin
			case (phase_q)
				PH_HEADER: begin
					if (!hdr_done) begin
						cnt_q <= cnt_inc;
					end else begin
						cnt_q <= '0;
						len_q <= dec_len;
						if (is_short || is_long) begin
							phase_q <= PH_CLOSED;
						end else if (!push_entry.last) begin
							bytes_left_q <= dec_len -
								{{(lpd_pkg::LenW - lpd_pkg::HlenW){1'b0}}, hl_eff};
							phase_q <= PH_BODY;
						end
					end
				end
				PH_BODY: begin
					if (push_entry.last) begin
						bytes_left_q <= '0;
						cnt_q <= '0;
						phase_q <= PH_HEADER;
					end else begin
						bytes_left_q <= bytes_left_q - 1'b1;
					end
				end
				default: begin
					phase_q <= PH_CLOSED;
				end
			endcase
		end
	end

	// Header byte storage.
	always_ff @(posedge clk) begin
		if (acc && phase_q == PH_HEADER &&
			cnt_q < lpd_pkg::HdrCntW'(lpd_pkg::MaxHeaderBytes)) begin
			store_q[cnt_q[lpd_pkg::HdrIdxW-1:0]] <= data_byte;
		end
	end

`ifndef SYNTH
	// Once closed, the front never leaves that phase and pushes nothing.
	a_closed_stays: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |=> phase_q == PH_CLOSED && !push)
		else $error("closed deframer reopened");
	// The header count never reaches the storage depth between transfers.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < lpd_pkg::HdrCntW'(lpd_pkg::MaxHeaderBytes))
		else $error("header count overflow");
	// An error command always closes the front.
	a_err_closes: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_entry.kind == lpd_pkg::KIND_ERR |=> phase_q == PH_CLOSED)
		else $error("error without closing");
`endif

endmodule

>>> design/lpd_queue.sv
`timescale 1ns / 1ps

// Command queue that lets the front and the back stall independently.
module lpd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lpd_pkg::entry_t push_entry,
	input logic pop,
	output logic full,
	output logic empty,
	output lpd_pkg::entry_t head
);

	lpd_pkg::entry_t mem_q [lpd_pkg::QueueDepth];
	logic [lpd_pkg::QPtrW-1:0] wr_ptr_q;
	logic [lpd_pkg::QPtrW-1:0] rd_ptr_q;
	logic [lpd_pkg::QCntW-1:0] cnt_q;

	assign full = cnt_q == lpd_pkg::QCntW'(lpd_pkg::QueueDepth);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

`ifndef SYNTH
	// A full queue takes a command only while it retires one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= lpd_pkg::QCntW'(lpd_pkg::QueueDepth))
		else $error("queue count out of range");
	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not follow a push");
`endif

endmodule

>>> design/lpd_back.sv
`timescale 1ns / 1ps

// Back part: expands each queued command into result transfers through an
// output register.
module lpd_back (
	input logic clk,
	input logic arst_n,
	input lpd_pkg::entry_t head,
	input logic empty,
	output logic pop,
	input logic out_stall,
	output logic out_valid,
	output logic [lpd_pkg::ByteW-1:0] out_byte,
	output logic first_of_packet,
	output logic last_of_packet,
	output logic [lpd_pkg::LenW-1:0] packet_length,
	output logic [lpd_pkg::ErrW-1:0] error_code,
	output logic end_of_burst
);

	logic [lpd_pkg::HdrIdxW-1:0] idx_q;
	logic out_valid_q;
	logic [lpd_pkg::ByteW-1:0] byte_q;
	logic first_q;
	logic last_q;
	logic [lpd_pkg::LenW-1:0] len_q;
	logic [lpd_pkg::ErrW-1:0] err_q;
	logic eob_q;

	logic load;
	logic last_res;
	logic [lpd_pkg::ByteW-1:0] n_byte;
	logic n_first;
	logic n_last;

	assign load = !empty && (!out_valid_q || !out_stall);
	assign last_res = (head.kind != lpd_pkg::KIND_HDR) ||
		(lpd_pkg::HlenW'(idx_q) == head.hlen - 1'b1);
	assign pop = load && last_res;

	// Fields of the next result from the head command.
	always_comb begin
		case (head.kind)
			lpd_pkg::KIND_HDR: begin
				n_byte = head.bytes[idx_q];
				n_first = idx_q == '0;
				n_last = last_res && head.last;
			end
			lpd_pkg::KIND_BODY: begin
				n_byte = head.bytes[0];
				n_first = 1'b0;
				n_last = head.last;
			end
			default: begin
				n_byte = '0;
				n_first = 1'b0;
				n_last = 1'b0;
			end
		endcase
	end

	// Burst position and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last_res ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= n_byte;
			first_q <= n_first;
			last_q <= n_last;
			len_q <= head.len;
			err_q <= head.err;
			eob_q <= last_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = byte_q;
	assign first_of_packet = first_q;
	assign last_of_packet = last_q;
	assign packet_length = len_q;
	assign error_code = err_q;
	assign end_of_burst = eob_q;

`ifndef SYNTH
	// A new result is loaded only when the previous one has left or is leaving.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !load)
		else $error("pending result overwritten");
	// The burst position rewinds whenever a command is retired.
	a_idx_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0)
		else $error("burst position not rewound");
	// An error result is always the end of its burst.
	a_err_eob: assert property (@(posedge clk) disable iff (!arst_n)
		load && head.kind == lpd_pkg::KIND_ERR |-> pop)
		else $error("error result not a single transfer");
`endif

endmodule
